FILE: sv/text_console_engine_assert.svh
// Assertion macros for the text console engine.
// Included by text_console_engine.sv; depends on nothing else.
`ifndef TEXT_CONSOLE_ENGINE_ASSERT_SVH
`define TEXT_CONSOLE_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define TCE_ASSERT_IMP(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("text console engine check failed");
`define TCE_ASSERT_NXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("text console engine check failed");
`else
`define TCE_ASSERT_IMP(label, clk, rst, cond, prop)
`define TCE_ASSERT_NXT(label, clk, rst, cond, prop)
`endif
`endif

FILE: sv/tce_pkg.sv
// Shared constants for the text console engine: geometry defaults, command
// codes, register indexes, character codes and stream field widths.
// No dependencies.
`default_nettype none

package tce_pkg;

  // Default screen geometry
  localparam int COLUMNS_DEFAULT = 80;
  localparam int ROWS_DEFAULT    = 25;

  // Command codes carried on the input tuser
  localparam logic [2:0] MODE_PUT    = 3'd0;
  localparam logic [2:0] MODE_CLEAR  = 3'd1;
  localparam logic [2:0] MODE_SET    = 3'd2;
  localparam logic [2:0] MODE_SCROLL = 3'd3;
  localparam logic [2:0] MODE_READ   = 3'd4;

  // Result kinds carried on the output tuser
  localparam logic KIND_CURSOR = 1'b0;
  localparam logic KIND_CELL   = 1'b1;

  // Configuration registers
  localparam int         CFG_INDEX_W   = 1;
  localparam int         CFG_DATA_W    = 8;
  localparam logic [0:0] REG_ATTRIBUTE = 1'b0;
  localparam logic [0:0] REG_BUFFER    = 1'b1;
  localparam logic [7:0] ATTR_RESET    = 8'h07;

  // Character codes
  localparam logic [7:0] CH_BS      = 8'h08;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] PRINT_LO   = 8'd32;
  localparam logic [7:0] PRINT_HI   = 8'd126;
  localparam logic [7:0] BLANK_CODE = 8'h20;
  localparam int         TAB_STEP   = 8;

  // Stream widths
  localparam int S_TUSER_W = 3;
  localparam int S_TDATA_W = 32;
  localparam int M_TUSER_W = 1;
  localparam int M_TDATA_W = 32;
  localparam int POS_W     = 11;
  localparam int WORD_W    = 16;
  localparam int M_PAD_W   = M_TDATA_W - POS_W - WORD_W;

endpackage

`default_nettype wire

FILE: sv/text_console_engine.sv
// Text console engine: cursor control and a ROWS x COLUMNS cell memory.
// Depends on tce_pkg and on text_console_engine_assert.svh.
//
//  channel   dir  handshake                 payload
//  s_*       in   s_tvalid / s_tready       tuser: mode; tdata: char, column, row, lines
//  m_*       out  m_tvalid / m_tready       tuser: kind; tdata: position, cell word
//  cfg_*     in   cfg_we                    cfg_index, cfg_data
//
// Put, set cursor and read go through the execute and done steps, and the done step
// raises the result; the next command is taken back in idle. Without a buffer, put
// and clear give no result. Clear, scroll and a put that scrolls sweep the memory:
// every cell passes once through the single write port of the cell memory.
// Reset clears cursor and registers; the cell memory is not cleared.
// One command is in work at a time; a stalled result holds the engine in its
// final step while the input side waits.
`default_nettype none

module text_console_engine #(
  parameter int COLUMNS = tce_pkg::COLUMNS_DEFAULT,
  parameter int ROWS    = tce_pkg::ROWS_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // configuration writes
  input  wire logic                            cfg_we,
  input  wire logic [tce_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [tce_pkg::CFG_DATA_W-1:0]  cfg_data,
  // commands
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [tce_pkg::S_TUSER_W-1:0]   s_tuser,  // mode[2:0]
  // char_code[7:0], column[15:8], row[23:16], line_count[29:24], zero[31:30]
  input  wire logic [tce_pkg::S_TDATA_W-1:0]   s_tdata,
  // results
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [tce_pkg::M_TUSER_W-1:0]        m_tuser,  // kind[0]
  // cursor_position[10:0], cell_word[26:11], zero[31:27]
  output logic [tce_pkg::M_TDATA_W-1:0]        m_tdata
);

  import tce_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(CELLS + 1);
  localparam int XW    = $clog2(COLUMNS);
  localparam int YW    = $clog2(ROWS);

  localparam logic [CW-1:0] CELLS_C = CW'(CELLS);
  localparam logic [CW-1:0] COLS_C  = CW'(COLUMNS);
  localparam logic [8:0]    COL_LIM = 9'(COLUMNS);
  localparam logic [8:0]    ROW_LIM = 9'(ROWS);
  localparam logic [XW:0]   X_LIM   = (XW + 1)'(COLUMNS);
  localparam logic [YW:0]   Y_LIM   = (YW + 1)'(ROWS);
  localparam logic [YW-1:0] Y_LAST  = YW'(ROWS - 1);
  localparam logic [5:0]    N_MAX   = 6'(ROWS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_COPY,
    S_BLANK,
    S_DONE
  } state_t;

  state_t state;

  // registers and cursor
  logic [7:0]    attribute;
  logic          buffer_present;
  logic [XW-1:0] cur_x;
  logic [YW-1:0] cur_y;

  // held command
  logic [2:0] mode_q;
  logic [7:0] char_q;
  logic [7:0] col_q;
  logic [7:0] row_q;
  logic [5:0] lines_q;

  // sweep control
  logic [CW-1:0] a;
  logic [CW-1:0] off;
  logic [CW-1:0] copy_end;
  logic          cp_valid;
  logic [AW-1:0] cp_addr;

  // cell memory
  logic [WORD_W-1:0] mem [CELLS];
  logic [WORD_W-1:0] rd_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;

  // derived values
  logic [XW:0]   px;
  logic [YW:0]   py;
  logic [XW:0]   tab_x;
  logic          put_wr;
  logic [XW-1:0] clamp_x;
  logic [YW-1:0] clamp_y;
  logic [AW-1:0] cur_addr;
  logic [AW-1:0] pick_addr;
  logic [CW:0]   copy_src;
  logic [5:0]    n_lines;
  logic [CW-1:0] n_off;
  logic [CW-1:0] pos_full;

  assign s_tready = (state == S_IDLE);

  // Clamp the signed coordinates to the screen
  always_comb begin
    if (col_q[7]) begin
      clamp_x = '0;
    end else if ({1'b0, col_q} >= COL_LIM) begin
      clamp_x = XW'(COLUMNS - 1);
    end else begin
      clamp_x = col_q[XW-1:0];
    end
    if (row_q[7]) begin
      clamp_y = '0;
    end else if ({1'b0, row_q} >= ROW_LIM) begin
      clamp_y = Y_LAST;
    end else begin
      clamp_y = row_q[YW-1:0];
    end
  end

  // Work out the cursor after one character
  always_comb begin
    px     = {1'b0, cur_x};
    py     = {1'b0, cur_y};
    put_wr = 1'b0;
    tab_x  = (px + (XW + 1)'(TAB_STEP)) & ~(XW + 1)'(TAB_STEP - 1);
    case (char_q)
      CH_LF: begin
        px = '0;
        py = py + 1'b1;
      end
      CH_CR: begin
        px = '0;
      end
      CH_TAB: begin
        px = tab_x;
        if (px >= X_LIM) begin
          px = '0;
          py = py + 1'b1;
        end
      end
      CH_BS: begin
        if (px != '0) px = px - 1'b1;
      end
      default: begin
        if (char_q >= PRINT_LO && char_q <= PRINT_HI) begin
          put_wr = 1'b1;
          px     = px + 1'b1;
          if (px >= X_LIM) begin
            px = '0;
            py = py + 1'b1;
          end
        end
      end
    endcase
  end

  // Addresses, scroll distance and linear cursor position
  assign cur_addr  = AW'(cur_y) * AW'(COLUMNS) + AW'(cur_x);
  assign pick_addr = AW'(clamp_y) * AW'(COLUMNS) + AW'(clamp_x);
  assign copy_src  = {1'b0, a} + {1'b0, off};
  assign n_lines   = (lines_q > N_MAX) ? N_MAX : lines_q;
  assign n_off     = CW'(n_lines) * COLS_C;
  assign pos_full  = CW'(cur_y) * COLS_C + CW'(cur_x);

  // Drive the memory ports from the current step
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur_addr;
    wr_data = {attribute, char_q};
    rd_en   = 1'b0;
    rd_addr = pick_addr;
    case (state)
      S_EXEC: begin
        if (mode_q == MODE_PUT && buffer_present && put_wr) wr_en = 1'b1;
        if (mode_q == MODE_READ) rd_en = 1'b1;
      end
      S_COPY: begin
        if (cp_valid) begin
          wr_en   = 1'b1;
          wr_addr = cp_addr;
          wr_data = rd_data;
        end
        if (a < copy_end) begin
          rd_en   = 1'b1;
          rd_addr = copy_src[AW-1:0];
        end
      end
      S_BLANK: begin
        wr_en   = 1'b1;
        wr_addr = a[AW-1:0];
        wr_data = {attribute, BLANK_CODE};
      end
      default: begin
      end
    endcase
  end

  // Cell memory write port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // Cell memory read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_addr];
  end

  // Sequencer, registers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      attribute      <= ATTR_RESET;
      buffer_present <= 1'b0;
      cur_x          <= '0;
      cur_y          <= '0;
      cp_valid       <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      // take configuration writes
      if (cfg_we) begin
        case (cfg_index)
          REG_ATTRIBUTE: attribute      <= cfg_data;
          REG_BUFFER:    buffer_present <= cfg_data[0];
          default: begin
          end
        endcase
      end

      // drop a result once the transaction completes, unless a new one follows
      if (m_tvalid && m_tready && state != S_DONE) m_tvalid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            mode_q  <= s_tuser;
            char_q  <= s_tdata[7:0];
            col_q   <= s_tdata[15:8];
            row_q   <= s_tdata[23:16];
            lines_q <= s_tdata[29:24];
            state   <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (mode_q)
            MODE_PUT: begin
              if (!buffer_present) begin
                state <= S_IDLE;
              end else begin
                cur_x <= px[XW-1:0];
                if (py >= Y_LIM) begin
                  cur_y    <= Y_LAST;
                  a        <= '0;
                  off      <= COLS_C;
                  copy_end <= CELLS_C - COLS_C;
                  state    <= S_COPY;
                end else begin
                  cur_y <= py[YW-1:0];
                  state <= S_DONE;
                end
              end
            end
            MODE_CLEAR: begin
              if (!buffer_present) begin
                state <= S_IDLE;
              end else begin
                cur_x <= '0;
                cur_y <= '0;
                a     <= '0;
                state <= S_BLANK;
              end
            end
            MODE_SET: begin
              cur_x <= clamp_x;
              cur_y <= clamp_y;
              state <= S_DONE;
            end
            MODE_SCROLL: begin
              if (n_lines == '0) begin
                state <= S_DONE;
              end else begin
                cur_y    <= Y_LAST;
                a        <= '0;
                off      <= n_off;
                copy_end <= CELLS_C - n_off;
                state    <= S_COPY;
              end
            end
            MODE_READ: begin
              state <= S_DONE;
            end
            default: begin
              state <= S_IDLE;
            end
          endcase
        end
        S_COPY: begin
          // read ahead by one cell, write back the previous read
          cp_valid <= (a < copy_end);
          cp_addr  <= a[AW-1:0];
          if (a < copy_end) begin
            a <= a + 1'b1;
          end else begin
            state <= S_BLANK;
          end
        end
        S_BLANK: begin
          if (a == CELLS_C - 1'b1) begin
            state <= S_DONE;
          end else begin
            a <= a + 1'b1;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            if (mode_q == MODE_READ) begin
              m_tuser <= KIND_CELL;
              m_tdata <= {M_PAD_W'(0), rd_data, POS_W'(pos_full)};
            end else begin
              m_tuser <= KIND_CURSOR;
              m_tdata <= {M_PAD_W'(0), WORD_W'(0), POS_W'(pos_full)};
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`include "text_console_engine_assert.svh"

  `TCE_ASSERT_IMP(a_cursor_on_screen, clk, rst, 1'b1, {1'b0, cur_x} < X_LIM && {1'b0, cur_y} < Y_LIM)
  `TCE_ASSERT_IMP(a_copy_src_in_range, clk, rst, (state == S_COPY) && (a < copy_end), copy_src < {1'b0, CELLS_C})
  `TCE_ASSERT_IMP(a_no_copy_in_blank, clk, rst, state == S_BLANK, !cp_valid)
  `TCE_ASSERT_NXT(a_accept_to_exec, clk, rst, s_tvalid && s_tready, state == S_EXEC)

endmodule

`default_nettype wire
